[rtl/dllc_pkg.sv]
// Shared types, constants and helpers for the doubly linked list unit.
`default_nettype none
package dllc_pkg;

  localparam int unsigned NODES  = 256;
  localparam int unsigned IDX_W  = $clog2(NODES + 1);
  localparam int unsigned ADDR_W = $clog2(NODES);
  localparam int unsigned DATA_W = 32;
  localparam int unsigned OP_W   = 5;
  localparam int unsigned STAT_W = 2;

  localparam logic [IDX_W-1:0] NIL = IDX_W'(NODES);

  localparam logic [STAT_W-1:0] ST_OK    = STAT_W'(0);
  localparam logic [STAT_W-1:0] ST_EMPTY = STAT_W'(1);
  localparam logic [STAT_W-1:0] ST_FULL  = STAT_W'(2);

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR      = 5'd0,
    OP_INS_FRONT  = 5'd1,
    OP_INS_BACK   = 5'd2,
    OP_CUR_FIRST  = 5'd3,
    OP_CUR_LAST   = 5'd4,
    OP_READ_FIRST = 5'd5,
    OP_READ_LAST  = 5'd6,
    OP_DEL_FIRST  = 5'd7,
    OP_DEL_LAST   = 5'd8,
    OP_DEL_AFTER  = 5'd9,
    OP_DEL_BEFORE = 5'd10,
    OP_INS_AFTER  = 5'd11,
    OP_INS_BEFORE = 5'd12,
    OP_READ_CUR   = 5'd13,
    OP_WRITE_CUR  = 5'd14,
    OP_FORWARD    = 5'd15,
    OP_BACK       = 5'd16
  } op_t;

  typedef struct packed {
    logic [OP_W-1:0]          operation;
    logic signed [DATA_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] read_value;
    logic [STAT_W-1:0]        status;
    logic                     cursor_active;
    logic                     error_seen;
  } out_item_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    logic [IDX_W-1:0] link;
  } link_wr_t;

  function automatic logic [IDX_W-1:0] fix_idx(input logic [IDX_W-1:0] idx);
    return (idx < NIL) ? idx : NIL;
  endfunction

endpackage
`default_nettype wire

[rtl/dllc_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none
module dllc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule
`default_nettype wire

[rtl/doubly_linked_list_with_cursor_unit.sv]
// Top level of the doubly linked list unit with cursor and free list.
//
// An operation is transferred at a rising edge where start is high and busy is low. Its
// result appears on out_data, flagged by out_valid for exactly one cycle; the receiver
// cannot stall it. Busy stays high in between, so the unit takes no new operation before
// the last one's result appears. The steps come from the node link memories: a read of a
// node, then a dependent read of its neighbor, followed by two writes through the single
// write port of each memory. Node storage is uninitialized after reset and needs no
// clearing pass; a clear operation runs through the same states as any other operation.
`default_nettype none
module doubly_linked_list_with_cursor_unit (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output logic                     busy,
  input  wire dllc_pkg::in_item_t  in_data,
  output logic                     out_valid,
  output dllc_pkg::out_item_t      out_data
);

  typedef enum logic [2:0] {S_IDLE, S_RA, S_RB, S_RC, S_W2} state_t;

  state_t                           state_r;
  logic [dllc_pkg::OP_W-1:0]        op_r;
  logic [dllc_pkg::DATA_W-1:0]      val_r;
  logic [dllc_pkg::IDX_W-1:0]       head_r, tail_r, cur_r, free_r, fresh_r;
  logic                             sticky_r;
  logic [dllc_pkg::IDX_W-1:0]       a_fwd_r, a_bwd_r;
  dllc_pkg::link_wr_t               wf2_r, wb2_r;
  logic                             out_valid_r;
  dllc_pkg::out_item_t              out_data_r;

  logic [dllc_pkg::IDX_W-1:0]       head_nxt, tail_nxt, cur_nxt, free_nxt, fresh_nxt;
  logic                             sticky_nxt;
  dllc_pkg::link_wr_t               wf1, wb1, wf2_nxt, wb2_nxt;
  logic                             dw_en;
  logic [dllc_pkg::IDX_W-1:0]       dw_addr;
  logic [dllc_pkg::STAT_W-1:0]      status_nxt;
  logic [dllc_pkg::DATA_W-1:0]      rd_nxt;

  logic [dllc_pkg::IDX_W-1:0]       fwd_q, bwd_q;
  logic [dllc_pkg::DATA_W-1:0]      data_q;
  logic [dllc_pkg::IDX_W-1:0]       b_fwd, b_bwd;
  logic [dllc_pkg::IDX_W-1:0]       n_take, take_free_nxt, take_fresh_nxt;
  logic                             take_from_free, full;

  logic [dllc_pkg::IDX_W-1:0]       fwd_rd_idx, bwd_rd_idx, data_rd_idx;
  logic                             link_rd_en, data_rd_en;
  dllc_pkg::link_wr_t               fwd_port, bwd_port;

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign b_fwd = dllc_pkg::fix_idx(fwd_q);
  assign b_bwd = dllc_pkg::fix_idx(bwd_q);

  assign take_from_free = (free_r != dllc_pkg::NIL);
  assign full           = !take_from_free && !(fresh_r < dllc_pkg::NIL);
  assign n_take         = take_from_free ? free_r : fresh_r;
  assign take_free_nxt  = take_from_free ? a_fwd_r : free_r;
  assign take_fresh_nxt = take_from_free ? fresh_r : fresh_r + dllc_pkg::IDX_W'(1);

  // Read addresses: the first read fetches the links of a known node, the second
  // fetches the neighbor's links (for insert after: the cursor's forward link).
  always_comb begin
    fwd_rd_idx  = cur_r;
    bwd_rd_idx  = cur_r;
    data_rd_idx = cur_r;
    link_rd_en  = 1'b0;
    data_rd_en  = 1'b0;
    unique case (state_r)
      S_RA: begin
        link_rd_en = 1'b1;
        data_rd_en = 1'b1;
        unique case (op_r)
          dllc_pkg::OP_INS_FRONT, dllc_pkg::OP_INS_BACK,
          dllc_pkg::OP_INS_AFTER, dllc_pkg::OP_INS_BEFORE: fwd_rd_idx = free_r;
          dllc_pkg::OP_DEL_FIRST: fwd_rd_idx = head_r;
          default: fwd_rd_idx = cur_r;
        endcase
        unique case (op_r)
          dllc_pkg::OP_DEL_LAST: bwd_rd_idx = tail_r;
          default: bwd_rd_idx = cur_r;
        endcase
        unique case (op_r)
          dllc_pkg::OP_READ_FIRST: data_rd_idx = head_r;
          dllc_pkg::OP_READ_LAST:  data_rd_idx = tail_r;
          default: data_rd_idx = cur_r;
        endcase
      end
      S_RB: begin
        link_rd_en = 1'b1;
        fwd_rd_idx = (op_r == dllc_pkg::OP_INS_AFTER) ? cur_r : b_fwd;
        bwd_rd_idx = b_bwd;
      end
      default: begin
        link_rd_en = 1'b0;
      end
    endcase
  end

  always_comb begin
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    cur_nxt    = cur_r;
    free_nxt   = free_r;
    fresh_nxt  = fresh_r;
    wf1        = '0;
    wb1        = '0;
    wf2_nxt    = '0;
    wb2_nxt    = '0;
    dw_en      = 1'b0;
    dw_addr    = n_take;
    status_nxt = dllc_pkg::ST_OK;
    rd_nxt     = '0;
    unique case (op_r)
      dllc_pkg::OP_CLEAR: begin
        head_nxt  = dllc_pkg::NIL;
        tail_nxt  = dllc_pkg::NIL;
        cur_nxt   = dllc_pkg::NIL;
        free_nxt  = dllc_pkg::NIL;
        fresh_nxt = '0;
      end
      dllc_pkg::OP_INS_FRONT: begin
        if (full) begin
          status_nxt = dllc_pkg::ST_FULL;
        end else begin
          dw_en     = 1'b1;
          free_nxt  = take_free_nxt;
          fresh_nxt = take_fresh_nxt;
          wb1       = '{1'b1, n_take, dllc_pkg::NIL};
          wf1       = '{1'b1, n_take, head_r};
          if (head_r != dllc_pkg::NIL) begin
            wb2_nxt = '{1'b1, head_r, n_take};
          end else begin
            tail_nxt = n_take;
          end
          head_nxt = n_take;
        end
      end
      dllc_pkg::OP_INS_BACK: begin
        if (full) begin
          status_nxt = dllc_pkg::ST_FULL;
        end else begin
          dw_en     = 1'b1;
          free_nxt  = take_free_nxt;
          fresh_nxt = take_fresh_nxt;
          wf1       = '{1'b1, n_take, dllc_pkg::NIL};
          wb1       = '{1'b1, n_take, tail_r};
          if (tail_r != dllc_pkg::NIL) begin
            wf2_nxt = '{1'b1, tail_r, n_take};
          end else begin
            head_nxt = n_take;
          end
          tail_nxt = n_take;
        end
      end
      dllc_pkg::OP_CUR_FIRST: begin
        cur_nxt = head_r;
      end
      dllc_pkg::OP_CUR_LAST: begin
        cur_nxt = tail_r;
      end
      dllc_pkg::OP_READ_FIRST: begin
        if (head_r == dllc_pkg::NIL) begin
          status_nxt = dllc_pkg::ST_EMPTY;
        end else begin
          rd_nxt = data_q;
        end
      end
      dllc_pkg::OP_READ_LAST: begin
        if (tail_r == dllc_pkg::NIL) begin
          status_nxt = dllc_pkg::ST_EMPTY;
        end else begin
          rd_nxt = data_q;
        end
      end
      dllc_pkg::OP_READ_CUR: begin
        if (cur_r == dllc_pkg::NIL) begin
          status_nxt = dllc_pkg::ST_EMPTY;
        end else begin
          rd_nxt = data_q;
        end
      end
      dllc_pkg::OP_DEL_FIRST: begin
        if (head_r != dllc_pkg::NIL) begin
          if (cur_r == head_r) begin
            cur_nxt = dllc_pkg::NIL;
          end
          if (head_r != tail_r) begin
            wb1      = '{1'b1, a_fwd_r, dllc_pkg::NIL};
            head_nxt = a_fwd_r;
          end else begin
            head_nxt = dllc_pkg::NIL;
            tail_nxt = dllc_pkg::NIL;
          end
          wf1      = '{1'b1, head_r, free_r};
          free_nxt = head_r;
        end
      end
      dllc_pkg::OP_DEL_LAST: begin
        if (tail_r != dllc_pkg::NIL) begin
          if (cur_r == tail_r) begin
            cur_nxt = dllc_pkg::NIL;
          end
          if (tail_r != head_r) begin
            wf1      = '{1'b1, a_bwd_r, dllc_pkg::NIL};
            tail_nxt = a_bwd_r;
          end else begin
            head_nxt = dllc_pkg::NIL;
            tail_nxt = dllc_pkg::NIL;
          end
          wf2_nxt  = '{1'b1, tail_r, free_r};
          free_nxt = tail_r;
        end
      end
      dllc_pkg::OP_DEL_AFTER: begin
        if (cur_r != dllc_pkg::NIL && cur_r != tail_r) begin
          if (a_fwd_r == tail_r) begin
            wf1      = '{1'b1, cur_r, dllc_pkg::NIL};
            tail_nxt = cur_r;
          end else begin
            wf1 = '{1'b1, cur_r, b_fwd};
            wb1 = '{1'b1, b_fwd, cur_r};
          end
          wf2_nxt  = '{1'b1, a_fwd_r, free_r};
          free_nxt = a_fwd_r;
        end
      end
      dllc_pkg::OP_DEL_BEFORE: begin
        if (cur_r != dllc_pkg::NIL && cur_r != head_r) begin
          if (a_bwd_r == head_r) begin
            wb1      = '{1'b1, cur_r, dllc_pkg::NIL};
            head_nxt = cur_r;
          end else begin
            wb1 = '{1'b1, cur_r, b_bwd};
            wf1 = '{1'b1, b_bwd, cur_r};
          end
          wf2_nxt  = '{1'b1, a_bwd_r, free_r};
          free_nxt = a_bwd_r;
        end
      end
      dllc_pkg::OP_INS_AFTER: begin
        if (cur_r != dllc_pkg::NIL) begin
          if (full) begin
            status_nxt = dllc_pkg::ST_FULL;
          end else begin
            dw_en     = 1'b1;
            free_nxt  = take_free_nxt;
            fresh_nxt = take_fresh_nxt;
            wb1       = '{1'b1, n_take, cur_r};
            if (cur_r == tail_r) begin
              wf1      = '{1'b1, n_take, dllc_pkg::NIL};
              tail_nxt = n_take;
            end else begin
              wb2_nxt = '{1'b1, b_fwd, n_take};
              wf1     = '{1'b1, n_take, b_fwd};
            end
            wf2_nxt = '{1'b1, cur_r, n_take};
          end
        end
      end
      dllc_pkg::OP_INS_BEFORE: begin
        if (cur_r != dllc_pkg::NIL) begin
          if (full) begin
            status_nxt = dllc_pkg::ST_FULL;
          end else begin
            dw_en     = 1'b1;
            free_nxt  = take_free_nxt;
            fresh_nxt = take_fresh_nxt;
            wf1       = '{1'b1, n_take, cur_r};
            if (cur_r == head_r) begin
              wb1      = '{1'b1, n_take, dllc_pkg::NIL};
              head_nxt = n_take;
            end else begin
              wf2_nxt = '{1'b1, a_bwd_r, n_take};
              wb1     = '{1'b1, n_take, a_bwd_r};
            end
            wb2_nxt = '{1'b1, cur_r, n_take};
          end
        end
      end
      dllc_pkg::OP_WRITE_CUR: begin
        if (cur_r != dllc_pkg::NIL) begin
          dw_en   = 1'b1;
          dw_addr = cur_r;
        end
      end
      dllc_pkg::OP_FORWARD: begin
        if (cur_r != dllc_pkg::NIL) begin
          cur_nxt = a_fwd_r;
        end
      end
      dllc_pkg::OP_BACK: begin
        if (cur_r != dllc_pkg::NIL) begin
          cur_nxt = a_bwd_r;
        end
      end
      default: begin
        status_nxt = dllc_pkg::ST_OK;
      end
    endcase
    sticky_nxt = sticky_r || (status_nxt != dllc_pkg::ST_OK);
  end

  always_comb begin
    fwd_port = '0;
    bwd_port = '0;
    unique case (state_r)
      S_RC: begin
        fwd_port = wf1;
        bwd_port = wb1;
      end
      S_W2: begin
        fwd_port = wf2_r;
        bwd_port = wb2_r;
      end
      default: begin
        fwd_port = '0;
      end
    endcase
  end

  dllc_ram #(
    .WIDTH (dllc_pkg::IDX_W),
    .DEPTH (dllc_pkg::NODES)
  ) u_fwd_ram (
    .clk     (clk),
    .wr_en   (fwd_port.en && (fwd_port.addr != dllc_pkg::NIL)),
    .wr_addr (fwd_port.addr[dllc_pkg::ADDR_W-1:0]),
    .wr_data (fwd_port.link),
    .rd_en   (link_rd_en),
    .rd_addr (fwd_rd_idx[dllc_pkg::ADDR_W-1:0]),
    .rd_data (fwd_q)
  );

  dllc_ram #(
    .WIDTH (dllc_pkg::IDX_W),
    .DEPTH (dllc_pkg::NODES)
  ) u_bwd_ram (
    .clk     (clk),
    .wr_en   (bwd_port.en && (bwd_port.addr != dllc_pkg::NIL)),
    .wr_addr (bwd_port.addr[dllc_pkg::ADDR_W-1:0]),
    .wr_data (bwd_port.link),
    .rd_en   (link_rd_en),
    .rd_addr (bwd_rd_idx[dllc_pkg::ADDR_W-1:0]),
    .rd_data (bwd_q)
  );

  dllc_ram #(
    .WIDTH (dllc_pkg::DATA_W),
    .DEPTH (dllc_pkg::NODES)
  ) u_data_ram (
    .clk     (clk),
    .wr_en   ((state_r == S_RC) && dw_en && (dw_addr != dllc_pkg::NIL)),
    .wr_addr (dw_addr[dllc_pkg::ADDR_W-1:0]),
    .wr_data (val_r),
    .rd_en   (data_rd_en),
    .rd_addr (data_rd_idx[dllc_pkg::ADDR_W-1:0]),
    .rd_data (data_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= dllc_pkg::NIL;
      tail_r      <= dllc_pkg::NIL;
      cur_r       <= dllc_pkg::NIL;
      free_r      <= dllc_pkg::NIL;
      fresh_r     <= '0;
      sticky_r    <= 1'b0;
      wf2_r       <= '0;
      wb2_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (state_r == S_W2);
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            op_r    <= in_data.operation;
            val_r   <= in_data.value;
            state_r <= S_RA;
          end
        end
        S_RA: begin
          state_r <= S_RB;
        end
        S_RB: begin
          a_fwd_r <= dllc_pkg::fix_idx(fwd_q);
          a_bwd_r <= dllc_pkg::fix_idx(bwd_q);
          state_r <= S_RC;
        end
        S_RC: begin
          head_r   <= head_nxt;
          tail_r   <= tail_nxt;
          cur_r    <= cur_nxt;
          free_r   <= free_nxt;
          fresh_r  <= fresh_nxt;
          sticky_r <= sticky_nxt;
          wf2_r    <= wf2_nxt;
          wb2_r    <= wb2_nxt;
          out_data_r.read_value    <= rd_nxt;
          out_data_r.status        <= status_nxt;
          out_data_r.cursor_active <= (cur_nxt != dllc_pkg::NIL);
          out_data_r.error_seen    <= sticky_nxt;
          state_r  <= S_W2;
        end
        S_W2: begin
          state_r <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire
